// ----- sv/event_energy_coincidence_selector_unit_macros.svh -----
// Assertion macros for the event energy coincidence selector checker.
// Depends on nothing; included by the checker file only.
`ifndef EVENT_ENERGY_COINCIDENCE_SELECTOR_UNIT_MACROS_SVH
`define EVENT_ENERGY_COINCIDENCE_SELECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EECS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define EECS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/eecs_pkg.sv -----
// Shared widths, codes, types and helpers for the event energy coincidence selector.
// No dependencies; imported by every module of the block.
package eecs_pkg;

   localparam int EVENT_ID_W     = 32;
   localparam int SUM_W          = 32;
   localparam int HIT_ENERGY_W   = 20;
   localparam int MAT_W          = 2;
   localparam int DET_IDX_W      = 6;
   localparam int MULT_W         = 7;
   localparam int ENERGY_BOUND_W = 33;
   localparam int MULT_BOUND_W   = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 33;

   // Fixed part of one closed-event record: id, germanium sum, argon sum.
   localparam int REC_FIXED_W = EVENT_ID_W + 2 * SUM_W;

   localparam int DEFAULT_NUM_DETECTORS = 64;
   localparam int DEFAULT_QUEUE_DEPTH   = 4;

   // Material classes
   localparam logic [MAT_W-1:0] MAT_ARGON_LIQUID       = 2'd1;
   localparam logic [MAT_W-1:0] MAT_GERMANIUM_ENRICHED = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_GE_ENERGY_MIN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GE_ENERGY_MAX    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ARGON_ENERGY_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ARGON_ENERGY_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MULT_MIN         = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MULT_MAX         = 3'd5;

   typedef struct packed {
      logic [ENERGY_BOUND_W-1:0] ge_energy_min;
      logic [ENERGY_BOUND_W-1:0] ge_energy_max;
      logic [ENERGY_BOUND_W-1:0] argon_energy_min;
      logic [ENERGY_BOUND_W-1:0] argon_energy_max;
      logic [MULT_BOUND_W-1:0]   mult_min;
      logic [MULT_BOUND_W-1:0]   mult_max;
   } cfg_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                                 input logic [HIT_ENERGY_W-1:0] energy);
      logic [SUM_W:0] sum;
      sum = {1'b0, acc} + (SUM_W + 1)'(energy);
      return sum[SUM_W] ? '1 : sum[SUM_W-1:0];
   endfunction

endpackage

// ----- sv/eecs_queue.sv -----
// Small request queue between the front and back parts of the selector.
// Depends on eecs_pkg (imported for house consistency of widths).
module eecs_queue import eecs_pkg::*; #(
   parameter int WIDTH = REC_FIXED_W,
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/eecs_front.sv -----
// Front part: takes hit requests, accumulates the open event, emits closed-event records.
// Depends on eecs_pkg; feeds eecs_queue.
module eecs_front import eecs_pkg::*; #(
   parameter int NUM_DETECTORS = DEFAULT_NUM_DETECTORS,
   parameter int ENTRY_W       = 2 * (REC_FIXED_W + NUM_DETECTORS) + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [EVENT_ID_W-1:0]   req_event_id,
   input  logic [MAT_W-1:0]        req_material_class,
   input  logic [HIT_ENERGY_W-1:0] req_hit_energy,
   input  logic [DET_IDX_W-1:0]    req_detector_index,
   input  logic                    req_end_of_stream,
   output logic                    q_push,
   output logic [ENTRY_W-1:0]      q_data,
   input  logic                    q_full
);

   localparam int REC_W = REC_FIXED_W + NUM_DETECTORS;

   logic                     open_ff, open_in;
   logic [EVENT_ID_W-1:0]    cur_ff, cur_in;
   logic [SUM_W-1:0]         ge_ff, ge_in;
   logic [SUM_W-1:0]         ar_ff, ar_in;
   logic [NUM_DETECTORS-1:0] map_ff, map_in;

   logic                     accept, close_old, keep;
   logic                     is_ge, is_ar;
   logic [SUM_W-1:0]         ge_add, ar_add;
   logic [NUM_DETECTORS-1:0] map_add;
   logic [REC_W-1:0]         rec_old, rec_new, rec0;

   assign req_full  = q_full;
   assign accept    = req_push && !q_full;
   assign close_old = open_ff && (req_event_id != cur_ff);
   assign keep      = open_ff && !close_old;
   assign is_ge     = (req_material_class == MAT_GERMANIUM_ENRICHED);
   assign is_ar     = (req_material_class == MAT_ARGON_LIQUID);

   always_comb begin
      cur_in = keep ? cur_ff : req_event_id;
      ge_add = keep ? ge_ff : '0;
      ar_add = keep ? ar_ff : '0;
      if (is_ge) begin
         ge_add = sat_add(ge_add, req_hit_energy);
      end
      if (is_ar) begin
         ar_add = sat_add(ar_add, req_hit_energy);
      end
      for (int i = 0; i < NUM_DETECTORS; i++) begin
         map_add[i] = (keep && map_ff[i]) ||
                      (is_ge && (req_detector_index == DET_IDX_W'(i)));
      end
   end

   // A changed event id closes the old event first; end of stream closes the updated one.
   assign rec_old = {cur_ff, ge_ff, ar_ff, map_ff};
   assign rec_new = {cur_in, ge_add, ar_add, map_add};
   assign rec0    = close_old ? rec_old : rec_new;
   assign q_push  = accept && (close_old || req_end_of_stream);
   assign q_data  = {close_old && req_end_of_stream, rec_new, rec0};

   always_comb begin
      open_in = open_ff;
      ge_in   = ge_ff;
      ar_in   = ar_ff;
      map_in  = map_ff;
      if (accept) begin
         open_in = !req_end_of_stream;
         ge_in   = req_end_of_stream ? '0 : ge_add;
         ar_in   = req_end_of_stream ? '0 : ar_add;
         map_in  = req_end_of_stream ? '0 : map_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         cur_ff  <= '0;
         ge_ff   <= '0;
         ar_ff   <= '0;
         map_ff  <= '0;
      end else begin
         open_ff <= open_in;
         ge_ff   <= ge_in;
         ar_ff   <= ar_in;
         map_ff  <= map_in;
         if (accept) begin
            cur_ff <= cur_in;
         end
      end
   end

endmodule

// ----- sv/eecs_back.sv -----
// Back part: unpacks queued records, counts multiplicity, applies windows, holds the result.
// Depends on eecs_pkg; fed by eecs_queue.
module eecs_back import eecs_pkg::*; #(
   parameter int NUM_DETECTORS = DEFAULT_NUM_DETECTORS,
   parameter int ENTRY_W       = 2 * (REC_FIXED_W + NUM_DETECTORS) + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic [ENTRY_W-1:0]    q_data,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [EVENT_ID_W-1:0] rsp_closed_event_id,
   output logic                  rsp_accepted,
   output logic [SUM_W-1:0]      rsp_ge_energy_sum,
   output logic [SUM_W-1:0]      rsp_argon_energy_sum,
   output logic [MULT_W-1:0]     rsp_multiplicity,
   output logic                  rsp_last
);

   localparam int REC_W  = REC_FIXED_W + NUM_DETECTORS;
   localparam int GROUPS = (NUM_DETECTORS + 7) / 8;
   localparam int PAD_W  = GROUPS * 8;

   logic                     sub_ff, sub_in;
   logic                     valid_ff, valid_in;
   logic                     load, two, sel_last;
   logic [REC_W-1:0]         sel;
   logic [NUM_DETECTORS-1:0] map;
   logic [PAD_W-1:0]         map_pad;
   logic [3:0]               group_cnt [GROUPS];
   logic [MULT_W-1:0]        mult;
   logic [SUM_W-1:0]         ge_sum, ar_sum;
   logic [EVENT_ID_W-1:0]    event_id;
   logic                     pass;

   function automatic logic energy_ok(input logic [SUM_W-1:0] value,
                                      input logic [ENERGY_BOUND_W-1:0] lo,
                                      input logic [ENERGY_BOUND_W-1:0] hi);
      logic lo_ok, hi_ok;
      lo_ok = lo[ENERGY_BOUND_W-1] || ({1'b0, value} >= lo);
      hi_ok = hi[ENERGY_BOUND_W-1] || ({1'b0, value} <= hi);
      return lo_ok && hi_ok;
   endfunction

   function automatic logic mult_ok(input logic [MULT_W-1:0] value,
                                    input logic [MULT_BOUND_W-1:0] lo,
                                    input logic [MULT_BOUND_W-1:0] hi);
      logic lo_ok, hi_ok;
      lo_ok = lo[MULT_BOUND_W-1] || ({1'b0, value} >= lo);
      hi_ok = hi[MULT_BOUND_W-1] || ({1'b0, value} <= hi);
      return lo_ok && hi_ok;
   endfunction

   assign two      = q_data[2*REC_W];
   assign sel      = sub_ff ? q_data[2*REC_W-1:REC_W] : q_data[REC_W-1:0];
   assign sel_last = !two || sub_ff;
   assign map      = sel[NUM_DETECTORS-1:0];
   assign ar_sum   = sel[NUM_DETECTORS +: SUM_W];
   assign ge_sum   = sel[NUM_DETECTORS + SUM_W +: SUM_W];
   assign event_id = sel[NUM_DETECTORS + 2*SUM_W +: EVENT_ID_W];
   assign map_pad  = PAD_W'(map);

   // Popcount in two short levels: bytes, then byte counts.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_cnt[g] = '0;
         for (int b = 0; b < 8; b++) begin
            group_cnt[g] = group_cnt[g] + 4'(map_pad[g*8 + b]);
         end
      end
      mult = '0;
      for (int g = 0; g < GROUPS; g++) begin
         mult = mult + MULT_W'(group_cnt[g]);
      end
   end

   assign pass = energy_ok(ge_sum, cfg.ge_energy_min, cfg.ge_energy_max) &&
                 energy_ok(ar_sum, cfg.argon_energy_min, cfg.argon_energy_max) &&
                 mult_ok(mult, cfg.mult_min, cfg.mult_max);

   assign load      = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop     = load && sel_last;
   assign rsp_empty = !valid_ff;

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      if (load) begin
         sub_in   = !sel_last;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_closed_event_id  <= event_id;
         rsp_accepted         <= pass;
         rsp_ge_energy_sum    <= ge_sum;
         rsp_argon_energy_sum <= ar_sum;
         rsp_multiplicity     <= mult;
         rsp_last             <= sel_last;
      end
   end

endmodule

// ----- sv/event_energy_coincidence_selector_unit.sv -----
// Top level of the event energy coincidence selector: CSR bank plus front, queue and back.
// Depends on eecs_pkg, eecs_front, eecs_queue, eecs_back.
//
//  - Request channel (req_*): one detector hit per request; taken when req_push is high
//    and req_full is low. A new event id or the end-of-stream flag closes the open event.
//  - Response channel (rsp_*): one response per closed event with the id, both
//    saturated sums, the germanium multiplicity and the window pass flag. The oldest
//    response sits on the ports while rsp_empty is low and leaves on rsp_pop.
//    rsp_last marks the final response caused by one request (a request can close
//    two events: the previous one and, on end of stream, its own).
//  - Throughput: one request and one response per cycle, except under the stalls below.
//  - Path: the accepting edge writes the record of a closed event into the queue, and
//    the output register loads it from there once it is empty or being popped. The
//    second response of a request appears in the cycle after the first is popped.
//  - Stall: the output register holds while rsp_pop is low; the queue between front
//    and back absorbs up to QUEUE_DEPTH requests' records, then req_full rises.
//  - Reset: clears the open event, queue and output valid flag; all window bounds go to -1
//    (disabled). The user must write CSRs only while the block is idle; it is unenforced.
module event_energy_coincidence_selector_unit import eecs_pkg::*; #(
   parameter int NUM_DETECTORS = DEFAULT_NUM_DETECTORS,
   parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration writes
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // hit requests
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [EVENT_ID_W-1:0]   req_event_id,
   input  logic [MAT_W-1:0]        req_material_class,
   input  logic [HIT_ENERGY_W-1:0] req_hit_energy,
   input  logic [DET_IDX_W-1:0]    req_detector_index,
   input  logic                    req_end_of_stream,
   // closed-event responses
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [EVENT_ID_W-1:0]   rsp_closed_event_id,
   output logic                    rsp_accepted,
   output logic [SUM_W-1:0]        rsp_ge_energy_sum,
   output logic [SUM_W-1:0]        rsp_argon_energy_sum,
   output logic [MULT_W-1:0]       rsp_multiplicity,
   output logic                    rsp_last
);

   // Queue entry: pair flag, second record, first record.
   localparam int REC_W   = REC_FIXED_W + NUM_DETECTORS;
   localparam int ENTRY_W = 2 * REC_W + 1;

   cfg_type              cfg_ff, cfg_in;
   logic                 q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0]   q_push_data, q_pop_data;

   // CSR bank: writes beyond the register list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_GE_ENERGY_MIN:    cfg_in.ge_energy_min    = csr_wdata;
            REG_GE_ENERGY_MAX:    cfg_in.ge_energy_max    = csr_wdata;
            REG_ARGON_ENERGY_MIN: cfg_in.argon_energy_min = csr_wdata;
            REG_ARGON_ENERGY_MAX: cfg_in.argon_energy_max = csr_wdata;
            REG_MULT_MIN:         cfg_in.mult_min = csr_wdata[MULT_BOUND_W-1:0];
            REG_MULT_MAX:         cfg_in.mult_max = csr_wdata[MULT_BOUND_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '1;   // every bound -1: window side disabled
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   eecs_front #(
      .NUM_DETECTORS (NUM_DETECTORS),
      .ENTRY_W       (ENTRY_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_event_id       (req_event_id),
      .req_material_class (req_material_class),
      .req_hit_energy     (req_hit_energy),
      .req_detector_index (req_detector_index),
      .req_end_of_stream  (req_end_of_stream),
      .q_push             (q_push),
      .q_data             (q_push_data),
      .q_full             (q_full)
   );

   eecs_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   eecs_back #(
      .NUM_DETECTORS (NUM_DETECTORS),
      .ENTRY_W       (ENTRY_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_data               (q_pop_data),
      .q_empty              (q_empty),
      .q_pop                (q_pop),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_closed_event_id  (rsp_closed_event_id),
      .rsp_accepted         (rsp_accepted),
      .rsp_ge_energy_sum    (rsp_ge_energy_sum),
      .rsp_argon_energy_sum (rsp_argon_energy_sum),
      .rsp_multiplicity     (rsp_multiplicity),
      .rsp_last             (rsp_last)
   );

endmodule

// ----- sv/eecs_checker.sv -----
// Port-level assertions for the event energy coincidence selector, bound to the top level.
// Depends on eecs_pkg and event_energy_coincidence_selector_unit_macros.svh.
`include "event_energy_coincidence_selector_unit_macros.svh"

module eecs_checker import eecs_pkg::*; #(
   parameter int NUM_DETECTORS = DEFAULT_NUM_DETECTORS
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_empty,
   input logic                    rsp_pop,
   input logic [EVENT_ID_W-1:0]   rsp_closed_event_id,
   input logic [MULT_W-1:0]       rsp_multiplicity,
   input logic                    rsp_last
);

   logic                  rsp_take;
   logic                  pair_ok;
   logic                  mult_in_range;
   logic [EVENT_ID_W-1:0] taken_id_ff;

   assign rsp_take      = rsp_pop && !rsp_empty;
   assign pair_ok       = !rsp_empty && (rsp_closed_event_id != taken_id_ff);
   assign mult_in_range = (rsp_multiplicity <= MULT_W'(NUM_DETECTORS));

   // id of the response taken last
   always_ff @(posedge clock) begin
      if (rsp_take) begin
         taken_id_ff <= rsp_closed_event_id;
      end
   end

   // Nothing to report right after reset.
   `EECS_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), rsp_empty, "response after reset")

   // A waiting response is not dropped.
   `EECS_ASSERT_NEXT(a_rsp_held, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty, "response dropped")

   // The second response of a pair follows at once and belongs to a different event.
   `EECS_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_take && !rsp_last, pair_ok, "bad pair")

   // Multiplicity never exceeds the number of detectors.
   `EECS_ASSERT_NOW(a_mult_range, clock, reset, !rsp_empty, mult_in_range, "multiplicity too big")

endmodule

bind event_energy_coincidence_selector_unit eecs_checker #(
   .NUM_DETECTORS (NUM_DETECTORS)
) u_checker (.*);

// ----- tb/eecs_event_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the event energy coincidence selector: watches the CSR, request and
// response ports, predicts every closed-event response and compares it. Uses eecs_pkg.
module eecs_event_checker import eecs_pkg::*; #(
   parameter int NUM_DETECTORS = DEFAULT_NUM_DETECTORS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_push,
   input  logic                    req_full,
   input  logic [EVENT_ID_W-1:0]   req_event_id,
   input  logic [MAT_W-1:0]        req_material_class,
   input  logic [HIT_ENERGY_W-1:0] req_hit_energy,
   input  logic [DET_IDX_W-1:0]    req_detector_index,
   input  logic                    req_end_of_stream,
   input  logic                    rsp_empty,
   input  logic                    rsp_pop,
   input  logic [EVENT_ID_W-1:0]   rsp_closed_event_id,
   input  logic                    rsp_accepted,
   input  logic [SUM_W-1:0]        rsp_ge_energy_sum,
   input  logic [SUM_W-1:0]        rsp_argon_energy_sum,
   input  logic [MULT_W-1:0]       rsp_multiplicity,
   input  logic                    rsp_last,
   output int                      outstanding,
   output int                      mismatches
);

   typedef struct {
      logic [EVENT_ID_W-1:0] event_id;
      logic                  accepted;
      logic [SUM_W-1:0]      ge_sum;
      logic [SUM_W-1:0]      argon_sum;
      logic [MULT_W-1:0]     multiplicity;
      logic                  last;
   } closed_event_rec;

   closed_event_rec awaited_events[$];

   // window bounds, two's complement, negative means that side is open
   logic signed [ENERGY_BOUND_W-1:0] ge_lo, ge_hi, argon_lo, argon_hi;
   logic signed [MULT_BOUND_W-1:0]   mult_lo, mult_hi;

   // open event
   logic                  event_is_open;
   logic [EVENT_ID_W-1:0] open_event_id;
   logic [SUM_W-1:0]      ge_total, argon_total;
   logic [63:0]           hit_map;

   function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] total,
                                                     input logic [HIT_ENERGY_W-1:0] energy);
      logic [SUM_W:0] wide;
      wide = {1'b0, total} + (SUM_W + 1)'(energy);
      return wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
   endfunction

   function automatic logic fits_window(input longint value, input longint lo,
                                        input longint hi);
      return (lo < 0 || value >= lo) && (hi < 0 || value <= hi);
   endfunction

   function automatic void close_open_event();
      closed_event_rec rec;
      int unsigned     hits;
      hits             = $countones(hit_map);
      rec.event_id     = open_event_id;
      rec.accepted     = fits_window(longint'(ge_total), longint'(ge_lo), longint'(ge_hi))
                      && fits_window(longint'(argon_total), longint'(argon_lo),
                                     longint'(argon_hi))
                      && fits_window(longint'(hits), longint'(mult_lo), longint'(mult_hi));
      rec.ge_sum       = ge_total;
      rec.argon_sum    = argon_total;
      rec.multiplicity = MULT_W'(hits);
      rec.last         = 1'b0;
      awaited_events.push_back(rec);
      ge_total      = '0;
      argon_total   = '0;
      hit_map       = '0;
      event_is_open = 1'b0;
   endfunction

   function automatic void absorb_hit();
      closed_event_rec rec;
      int              queued_before;
      queued_before = awaited_events.size();
      if (event_is_open && req_event_id != open_event_id)
         close_open_event();
      if (!event_is_open) begin
         event_is_open = 1'b1;
         open_event_id = req_event_id;
      end
      if (req_material_class == MAT_ARGON_LIQUID) begin
         argon_total = add_clamped(argon_total, req_hit_energy);
      end else if (req_material_class == MAT_GERMANIUM_ENRICHED) begin
         ge_total = add_clamped(ge_total, req_hit_energy);
         if (int'(req_detector_index) < NUM_DETECTORS)
            hit_map[req_detector_index] = 1'b1;
      end
      if (req_end_of_stream)
         close_open_event();
      // flag the final response of this request
      if (awaited_events.size() > queued_before) begin
         rec      = awaited_events.pop_back();
         rec.last = 1'b1;
         awaited_events.push_back(rec);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got, input logic [31:0] id);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s of event %h: expected %h, got %h", name, id, want, got);
      end
   endfunction

   function automatic void compare_response();
      closed_event_rec rec;
      if (awaited_events.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response for event %h", rsp_closed_event_id);
      end else begin
         rec = awaited_events.pop_front();
         check_field("closed_event_id", 64'(rec.event_id), 64'(rsp_closed_event_id),
                     rec.event_id);
         check_field("accepted", 64'(rec.accepted), 64'(rsp_accepted), rec.event_id);
         check_field("ge_energy_sum", 64'(rec.ge_sum), 64'(rsp_ge_energy_sum), rec.event_id);
         check_field("argon_energy_sum", 64'(rec.argon_sum), 64'(rsp_argon_energy_sum),
                     rec.event_id);
         check_field("multiplicity", 64'(rec.multiplicity), 64'(rsp_multiplicity),
                     rec.event_id);
         check_field("last", 64'(rec.last), 64'(rsp_last), rec.event_id);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ge_lo         = '1;
         ge_hi         = '1;
         argon_lo      = '1;
         argon_hi      = '1;
         mult_lo       = '1;
         mult_hi       = '1;
         event_is_open = 1'b0;
         open_event_id = '0;
         ge_total      = '0;
         argon_total   = '0;
         hit_map       = '0;
         awaited_events.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_GE_ENERGY_MIN:    ge_lo    = csr_wdata;
               REG_GE_ENERGY_MAX:    ge_hi    = csr_wdata;
               REG_ARGON_ENERGY_MIN: argon_lo = csr_wdata;
               REG_ARGON_ENERGY_MAX: argon_hi = csr_wdata;
               REG_MULT_MIN:         mult_lo  = csr_wdata[MULT_BOUND_W-1:0];
               REG_MULT_MAX:         mult_hi  = csr_wdata[MULT_BOUND_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full)
            absorb_hit();
         if (!rsp_empty && rsp_pop)
            compare_response();
      end
      outstanding <= awaited_events.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the event energy coincidence selector testbench: clock, reset, hit stimulus,
// window settings and the verdict. Uses eecs_pkg, the block and eecs_event_checker.
module tb_top;
   import eecs_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_SLACK = 8;      // settling edges waited after every predicted response is out
   localparam int LONG_HITS   = 40;     // max-energy hits of the long event

   // classes with no named code in the package
   localparam logic [MAT_W-1:0] MAT_OTHER  = 2'd0;
   localparam logic [MAT_W-1:0] MAT_UNUSED = 2'd3;

   localparam logic [ENERGY_BOUND_W-1:0] ENERGY_OFF = '1;
   localparam logic [ENERGY_BOUND_W-1:0] ENERGY_TOP = 33'h0_FFFF_FFFF;
   localparam logic [MULT_BOUND_W-1:0]   MULT_OFF   = '1;
   localparam logic [MULT_BOUND_W-1:0]   MULT_TOP   = 8'd64;

   // sums of the long event: 20 germanium and 20 argon hits of 1048575
   localparam logic [ENERGY_BOUND_W-1:0] LONG_SUM  = 33'd20971500;
   localparam logic [MULT_BOUND_W-1:0]   LONG_MULT = 8'd20;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_push = 1'b0;
   logic                    req_full;
   logic [EVENT_ID_W-1:0]   req_event_id = '0;
   logic [MAT_W-1:0]        req_material_class = '0;
   logic [HIT_ENERGY_W-1:0] req_hit_energy = '0;
   logic [DET_IDX_W-1:0]    req_detector_index = '0;
   logic                    req_end_of_stream = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop = 1'b0;
   logic [EVENT_ID_W-1:0]   rsp_closed_event_id;
   logic                    rsp_accepted;
   logic [SUM_W-1:0]        rsp_ge_energy_sum;
   logic [SUM_W-1:0]        rsp_argon_energy_sum;
   logic [MULT_W-1:0]       rsp_multiplicity;
   logic                    rsp_last;

   int outstanding;
   int mismatches;
   int cycle_count = 0;

   // idle percentages, changed per phase
   int send_idle_pct = 0;
   int pop_stall_pct = 0;

   // event numbering of the random stream
   logic [EVENT_ID_W-1:0] stream_id = '0;
   logic                  stream_closed = 1'b0;

   event_energy_coincidence_selector_unit i_dut (.*);

   eecs_event_checker i_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: drops pop at random according to the phase's stall rate.
   always @(posedge clock)
      rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // One hit request. The optional gap comes first; push stays high across
   // back-to-back requests so it never sees two assignments in one step.
   task automatic send_hit(input logic [EVENT_ID_W-1:0] id, input logic [MAT_W-1:0] mat,
                           input logic [HIT_ENERGY_W-1:0] energy,
                           input logic [DET_IDX_W-1:0] det, input logic eos);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct)
            @(posedge clock);
      end
      req_push           <= 1'b1;
      req_event_id       <= id;
      req_material_class <= mat;
      req_hit_energy     <= energy;
      req_detector_index <= det;
      req_end_of_stream  <= eos;
      // full is read before the edge's updates land, i.e. as the block saw it
      do @(posedge clock); while (req_full);
   endtask

   // Stop sending and wait for every predicted response, then let the pipe settle.
   // The first edge lets the checker's count catch up with the last request.
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic apply_windows(input logic [ENERGY_BOUND_W-1:0] ge_lo, ge_hi,
                                input logic [ENERGY_BOUND_W-1:0] ar_lo, ar_hi,
                                input logic [MULT_BOUND_W-1:0] m_lo, m_hi);
      write_register(REG_GE_ENERGY_MIN, ge_lo);
      write_register(REG_GE_ENERGY_MAX, ge_hi);
      write_register(REG_ARGON_ENERGY_MIN, ar_lo);
      write_register(REG_ARGON_ENERGY_MAX, ar_hi);
      write_register(REG_MULT_MIN, {{(CSR_DATA_W-MULT_BOUND_W){m_lo[MULT_BOUND_W-1]}}, m_lo});
      write_register(REG_MULT_MAX, {{(CSR_DATA_W-MULT_BOUND_W){m_hi[MULT_BOUND_W-1]}}, m_hi});
      csr_write_enable <= 1'b0;
   endtask

   // Energy bound around the sums a handful of hits reach; disabled a quarter of the time.
   function automatic logic [ENERGY_BOUND_W-1:0] pick_energy_bound();
      if ($urandom_range(0, 3) == 0)
         return ENERGY_OFF;
      return ENERGY_BOUND_W'($urandom_range(0, 3000000));
   endfunction

   function automatic logic [MULT_BOUND_W-1:0] pick_mult_bound();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return MULT_OFF;
      if (r == 3)
         return MULT_TOP;
      return MULT_BOUND_W'($urandom_range(0, 6));
   endfunction

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
         1: begin send_idle_pct = 75; pop_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  pop_stall_pct = 75; end
         default: begin send_idle_pct = 28; pop_stall_pct = 28; end
      endcase
   endtask

   // Mostly well-formed events of a few hits with random content; some stray
   // hits with foreign ids and stray end-of-stream flags break them up.
   task automatic run_event_stream(input int hit_budget);
      int                    sent;
      int                    hits;
      int                    r;
      logic [EVENT_ID_W-1:0] id;
      logic [MAT_W-1:0]      mat;
      logic [HIT_ENERGY_W-1:0] energy;
      logic                  eos;
      sent = 0;
      while (sent < hit_budget) begin
         r = $urandom_range(0, 99);
         if (r < 15)
            stream_id = $urandom;
         else if (!(r < 22 && stream_closed))
            stream_id = stream_id + EVENT_ID_W'($urandom_range(1, 3));
         // else: reuse the id of an event that was just ended by end of stream
         hits = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         for (int k = 0; k < hits; k++) begin
            id = ($urandom_range(0, 99) < 5) ? EVENT_ID_W'($urandom) : stream_id;
            r  = $urandom_range(0, 99);
            if (r < 45)
               mat = MAT_GERMANIUM_ENRICHED;
            else if (r < 80)
               mat = MAT_ARGON_LIQUID;
            else if (r < 90)
               mat = MAT_OTHER;
            else
               mat = MAT_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 45)
               energy = HIT_ENERGY_W'($urandom_range(0, 5000));
            else if (r < 90)
               energy = HIT_ENERGY_W'($urandom);
            else
               energy = '1;
            eos = (k == hits - 1) ? ($urandom_range(0, 99) < 20)
                                  : ($urandom_range(0, 99) < 3);
            send_hit(id, mat, energy, DET_IDX_W'($urandom_range(0, 63)), eos);
            stream_closed = eos;
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset windows (all open, so every event passes).
      // First hit opens event 0; nothing comes out for the idle state.
      send_hit(32'd0, MAT_GERMANIUM_ENRICHED, 20'd0, 6'd0, 1'b0);
      send_hit(32'd0, MAT_ARGON_LIQUID, 20'hFFFFF, 6'd63, 1'b0);
      send_hit(32'd0, MAT_GERMANIUM_ENRICHED, 20'hFFFFF, 6'd63, 1'b0);
      // same detector twice counts once
      send_hit(32'd0, MAT_GERMANIUM_ENRICHED, 20'd1, 6'd63, 1'b0);
      // unused class and other class add nothing
      send_hit(32'd0, MAT_UNUSED, 20'hFFFFF, 6'd1, 1'b0);
      send_hit(32'd0, MAT_OTHER, 20'hFFFFF, 6'd2, 1'b0);
      // new id plus end of stream: closes event 0 and its own event, two responses
      send_hit(32'hFFFF_FFFF, MAT_GERMANIUM_ENRICHED, 20'd100, 6'd5, 1'b1);
      // hits after end of stream reopen, even with the id just closed
      send_hit(32'hFFFF_FFFF, MAT_ARGON_LIQUID, 20'd7, 6'd0, 1'b0);
      send_hit(32'hFFFF_FFFF, MAT_GERMANIUM_ENRICHED, 20'd3, 6'd62, 1'b1);
      // single-hit event with empty sums
      send_hit(32'd7, MAT_OTHER, 20'd0, 6'd0, 1'b1);
      send_hit(32'd7, MAT_GERMANIUM_ENRICHED, 20'h55555, 6'h2A, 1'b0);
      send_hit(32'd7, MAT_ARGON_LIQUID, 20'hAAAAA, 6'h15, 1'b0);
      send_hit(32'd8, MAT_GERMANIUM_ENRICHED, 20'hAAAAA, 6'h15, 1'b0);
      send_hit(32'h8000_0000, MAT_ARGON_LIQUID, 20'd1, 6'd0, 1'b0);
      send_hit(32'h7FFF_FFFF, MAT_UNUSED, 20'd0, 6'd63, 1'b1);
      wait_drained();

      // Long event of max-energy hits on twenty detectors; the germanium and
      // multiplicity windows are closed on the exact values, so only exact sums pass.
      apply_windows(LONG_SUM, LONG_SUM, '0, ENERGY_OFF, LONG_MULT, LONG_MULT);
      for (int k = 0; k < LONG_HITS; k++)
         send_hit(32'h0012_3400, k[0] ? MAT_ARGON_LIQUID : MAT_GERMANIUM_ENRICHED, '1,
                  DET_IDX_W'(k / 2), k == LONG_HITS - 1);
      wait_drained();

      // Random phases: window settings change only between phases, with the block idle.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_windows(ENERGY_OFF, ENERGY_OFF, ENERGY_OFF, ENERGY_OFF,
                             MULT_OFF, MULT_OFF);
            1: apply_windows('0, ENERGY_TOP, '0, ENERGY_TOP, '0, MULT_TOP);
            2: apply_windows('0, '0, '0, '0, '0, '0);
            default: apply_windows(pick_energy_bound(), pick_energy_bound(),
                                   pick_energy_bound(), pick_energy_bound(),
                                   pick_mult_bound(), pick_mult_bound());
         endcase
         set_idle_mode(phase % 4);
         if (phase == 5) begin
            // hold off mid-stream until everything predicted so far is out
            run_event_stream(55);
            wait_drained();
            run_event_stream(55);
         end else begin
            run_event_stream(110);
         end
         wait_drained();
      end

      set_idle_mode(0);
      wait_drained();
      if (mismatches == 0 && outstanding == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
